FILE: rtl/ptc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptc_pkg;

    // register indexes of the configuration port
    typedef enum logic [2:0] {
        CFG_PROP_GAIN   = 3'd0,
        CFG_DERIV_GAIN  = 3'd1,
        CFG_INTEG_GAIN  = 3'd2,
        CFG_TICK_RATE   = 3'd3,
        CFG_SETTLE_THR  = 3'd4,
        CFG_TICK_LIMIT  = 3'd5
    } t_cfg_idx;

    // request kinds carried in tuser
    localparam logic FUNC_START  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam int SPEED_MAX = 6400;
    localparam int SPD_W     = 14;
    localparam int GAIN_W    = 24;

    // saturation bound of one gain product
    localparam logic [47:0] TERM_LIMIT = 48'h0100_0000_0000;

    localparam logic [23:0] PROP_GAIN_RST  = 24'd45875;
    localparam logic [23:0] DERIV_GAIN_RST = 24'd655;
    localparam logic [23:0] INTEG_GAIN_RST = 24'd0;
    localparam logic [9:0]  TICK_RATE_RST  = 10'd20;
    localparam logic [15:0] SETTLE_THR_RST = 16'd128;
    localparam logic [9:0]  TICK_LIMIT_RST = 10'd80;

endpackage

`default_nettype wire

FILE: rtl/pid_turn_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// start requests and samples while idle: result registered directly on accept
// running sample that stops the turn: S_CHK, then S_OUT until the output is free
// running sample that drives the motors: the one 24x24 multiplier does
//   two partial products for each of four products in turn
// one request in flight at a time; s_tready is low while a sample is worked on
// i_rst_n is synchronous active low: gains back to defaults, turn idle, no result

module pid_turn_controller #(
    parameter int GAIN_FRAC_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // angle[31:0], turn_amount[55:32]
    input  wire logic [0:0]  s_tuser,   // func[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // left_vel[13:0], right_vel[27:14], zero pad
    output logic [0:0]       m_tuser,   // done_res[0]
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data
);

    localparam int SUM_W = 43;
    localparam int SPD_W = ptc_pkg::SPD_W;
    localparam logic signed [SUM_W-1:0] L_SPD_MAX = SUM_W'(ptc_pkg::SPEED_MAX);
    localparam logic signed [SUM_W-1:0] L_SPD_MIN = -L_SPD_MAX;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_DIFF, S_MHI, S_MLO, S_ACC, S_SUM, S_FIN, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        T_DER, T_PROP, T_DERIV, T_INTEG
    } t_term;

    // configuration
    logic [23:0] r_prop_gain, r_deriv_gain, r_integ_gain;
    logic [9:0]  r_tick_rate, r_tick_limit;
    logic [15:0] r_settle_thr;

    // control state
    t_state r_state;
    t_term  r_term;
    logic   r_running;
    logic   r_out_valid;
    logic   r_sat_en;
    logic   r_neg;
    logic   r_res_done;

    // turn state and datapath
    logic signed [32:0]      r_target;
    logic signed [33:0]      r_last_err;
    logic signed [46:0]      r_derivative;
    logic signed [47:0]      r_integral;
    logic [9:0]              r_tick;
    logic [33:0]             r_mag_le;
    logic [46:0]             r_mag_d;
    logic signed [31:0]      r_ang;
    logic signed [33:0]      r_err;
    logic [47:0]             r_mag;
    logic [23:0]             r_gain;
    logic [47:0]             r_prod;
    logic [47:0]             r_hi;
    logic [47:0]             r_p;
    logic signed [SUM_W-1:0] r_sum;
    logic [SPD_W-1:0]        r_speed;
    logic [SPD_W-1:0]        r_out_left, r_out_right;
    logic                    r_out_done;

    logic                    w_accept;
    logic signed [31:0]      w_ang;
    logic signed [23:0]      w_rot;
    logic [23:0]             w_rot_mag;
    logic                    w_start_stop;
    logic signed [32:0]      w_target;
    logic signed [33:0]      w_err;
    logic [47:0]             w_settle_sum;
    logic                    w_stop;
    logic signed [34:0]      w_diff;
    logic [34:0]             w_diff_mag;
    logic [33:0]             w_err_mag;
    logic [47:0]             w_int_mag;
    logic [23:0]             w_mul_a;
    logic [47:0]             w_prod;
    logic [48:0]             w_acc;
    logic                    w_sat;
    logic signed [SUM_W-1:0] w_tmag, w_term;
    logic [46:0]             w_der_mag;
    logic signed [SUM_W-1:0] w_shift;
    logic                    w_out_free;
    logic                    w_out_load;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= ptc_pkg::PROP_GAIN_RST;
            r_deriv_gain <= ptc_pkg::DERIV_GAIN_RST;
            r_integ_gain <= ptc_pkg::INTEG_GAIN_RST;
            r_tick_rate  <= ptc_pkg::TICK_RATE_RST;
            r_settle_thr <= ptc_pkg::SETTLE_THR_RST;
            r_tick_limit <= ptc_pkg::TICK_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (ptc_pkg::t_cfg_idx'(i_cfg_index))
                ptc_pkg::CFG_PROP_GAIN:  r_prop_gain  <= i_cfg_data;
                ptc_pkg::CFG_DERIV_GAIN: r_deriv_gain <= i_cfg_data;
                ptc_pkg::CFG_INTEG_GAIN: r_integ_gain <= i_cfg_data;
                ptc_pkg::CFG_TICK_RATE:  r_tick_rate  <= i_cfg_data[9:0];
                ptc_pkg::CFG_SETTLE_THR: r_settle_thr <= i_cfg_data[15:0];
                ptc_pkg::CFG_TICK_LIMIT: r_tick_limit <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    assign w_out_free = !r_out_valid || m_tready;
    assign s_tready   = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = s_tvalid && s_tready;

    // result register loads on a start, an idle sample or a finished sample
    assign w_out_load = ((r_state == S_IDLE) && w_accept
                         && ((s_tuser[0] == ptc_pkg::FUNC_START) || !r_running))
                     || ((r_state == S_OUT) && w_out_free);

    assign w_ang        = $signed(s_tdata[31:0]);
    assign w_rot        = $signed(s_tdata[55:32]);
    assign w_rot_mag    = w_rot[23] ? 24'(-w_rot) : 24'(w_rot);
    assign w_start_stop = ({8'd0, r_settle_thr} >= w_rot_mag) || (r_tick_limit == 10'd0);
    assign w_target     = {w_ang[31], w_ang} + {{9{w_rot[23]}}, w_rot};

    assign w_err        = {r_target[32], r_target} - {{2{r_ang[31]}}, r_ang};
    assign w_settle_sum = {14'd0, r_mag_le} + {1'b0, r_mag_d};
    assign w_stop       = (r_tick >= r_tick_limit)
                       || ((r_tick != 10'd0) && (w_settle_sum <= {32'd0, r_settle_thr}));

    assign w_diff     = {r_err[33], r_err} - {r_last_err[33], r_last_err};
    assign w_diff_mag = w_diff[34] ? 35'(-w_diff) : 35'(w_diff);
    assign w_err_mag  = r_err[33] ? 34'(-r_err) : 34'(r_err);
    assign w_int_mag  = r_integral[47] ? 48'(-r_integral) : 48'(r_integral);

    // shared multiplier: high partial product first, then low
    assign w_mul_a = (r_state == S_MHI) ? r_mag[47:24] : r_mag[23:0];
    assign w_prod  = 48'(w_mul_a) * 48'(r_gain);

    assign w_acc = {1'b0, r_hi[23:0], 24'd0} + {1'b0, r_prod};
    assign w_sat = r_sat_en && ((r_hi[47:16] != 32'd0) || (w_acc > {1'b0, ptc_pkg::TERM_LIMIT}));

    assign w_tmag    = {2'b00, r_p[40:0]};
    assign w_term    = r_neg ? -w_tmag : w_tmag;
    assign w_der_mag = r_p[46:0];

    // floor division by the gain scale
    assign w_shift = r_sum >>> GAIN_FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_term       <= T_DER;
            r_running    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_sat_en     <= 1'b0;
            r_neg        <= 1'b0;
            r_res_done   <= 1'b0;
            r_target     <= '0;
            r_last_err   <= '0;
            r_derivative <= '0;
            r_integral   <= '0;
            r_tick       <= '0;
            r_mag_le     <= '0;
            r_mag_d      <= '0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_tvalid && m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_ang <= w_ang;
                        if (s_tuser[0] == ptc_pkg::FUNC_START) begin
                            r_target     <= w_target;
                            r_last_err   <= '0;
                            r_derivative <= '0;
                            r_integral   <= '0;
                            r_tick       <= '0;
                            r_mag_le     <= '0;
                            r_mag_d      <= '0;
                            r_running    <= !w_start_stop;
                            r_out_left   <= '0;
                            r_out_right  <= '0;
                            r_out_done   <= w_start_stop;
                        end else if (!r_running) begin
                            r_out_left  <= '0;
                            r_out_right <= '0;
                            r_out_done  <= 1'b1;
                        end else begin
                            r_state <= S_CHK;
                        end
                    end
                end
                S_CHK: begin
                    r_err <= w_err;
                    if (w_stop) begin
                        r_running  <= 1'b0;
                        r_speed    <= '0;
                        r_res_done <= 1'b1;
                        r_state    <= S_OUT;
                    end else begin
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_integral <= r_integral + {{14{r_err[33]}}, r_err};
                    r_last_err <= r_err;
                    r_mag_le   <= w_err_mag;
                    r_tick     <= r_tick + 10'd1;
                    r_mag      <= {13'd0, w_diff_mag};
                    r_neg      <= w_diff[34];
                    r_gain     <= {14'd0, r_tick_rate};
                    r_sat_en   <= 1'b0;
                    r_term     <= T_DER;
                    r_state    <= S_MHI;
                end
                S_MHI: begin
                    r_prod  <= w_prod;
                    r_state <= S_MLO;
                end
                S_MLO: begin
                    r_hi    <= r_prod;
                    r_prod  <= w_prod;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_p     <= w_sat ? ptc_pkg::TERM_LIMIT : w_acc[47:0];
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_sat_en <= 1'b1;
                    case (r_term)
                        T_DER: begin
                            r_derivative <= r_neg ? -$signed(w_der_mag) : $signed(w_der_mag);
                            r_mag_d      <= w_der_mag;
                            r_sum        <= '0;
                            r_mag        <= {14'd0, w_err_mag};
                            r_neg        <= r_err[33];
                            r_gain       <= r_prop_gain;
                            r_term       <= T_PROP;
                            r_state      <= S_MHI;
                        end
                        T_PROP: begin
                            r_sum   <= r_sum + w_term;
                            r_mag   <= {1'b0, r_mag_d};
                            r_neg   <= r_derivative[46];
                            r_gain  <= r_deriv_gain;
                            r_term  <= T_DERIV;
                            r_state <= S_MHI;
                        end
                        T_DERIV: begin
                            r_sum   <= r_sum + w_term;
                            r_mag   <= w_int_mag;
                            r_neg   <= r_integral[47];
                            r_gain  <= r_integ_gain;
                            r_term  <= T_INTEG;
                            r_state <= S_MHI;
                        end
                        default: begin
                            r_sum   <= r_sum + w_term;
                            r_state <= S_FIN;
                        end
                    endcase
                end
                S_FIN: begin
                    if (w_shift > L_SPD_MAX) begin
                        r_speed <= L_SPD_MAX[SPD_W-1:0];
                    end else if (w_shift < L_SPD_MIN) begin
                        r_speed <= L_SPD_MIN[SPD_W-1:0];
                    end else begin
                        r_speed <= w_shift[SPD_W-1:0];
                    end
                    r_res_done <= 1'b0;
                    r_state    <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_left  <= r_speed;
                        r_out_right <= -r_speed;
                        r_out_done  <= r_res_done;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {4'd0, r_out_right, r_out_left};
    assign m_tuser  = r_out_done;

endmodule

`default_nettype wire

FILE: rtl/ptc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ptc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    localparam logic signed [13:0] L_MAX = 14'(ptc_pkg::SPEED_MAX);
    localparam logic signed [13:0] L_MIN = -L_MAX;

    // right motor always mirrors the left one
    a_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[27:14] == 14'(~m_tdata[13:0] + 14'd1)))
        else $error("right speed is not the negated left speed");

    // a finished turn stops the motors
    a_done_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[27:0] == 28'd0))
        else $error("done result with nonzero speed");

    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (($signed(m_tdata[13:0]) <= L_MAX) && ($signed(m_tdata[13:0]) >= L_MIN)
                      && (m_tdata[31:28] == 4'd0)))
        else $error("speed outside the saturation range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind pid_turn_controller ptc_checker u_ptc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int GAIN_FRAC = 16;
    localparam int SPD_W     = ptc_pkg::SPD_W;
    localparam int SPEED_MAX = ptc_pkg::SPEED_MAX;
    localparam logic FUNC_START  = ptc_pkg::FUNC_START;
    localparam logic FUNC_SAMPLE = ptc_pkg::FUNC_SAMPLE;
    // register indexes past the end of the list, written only to be ignored
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;
    localparam int NUM_PHASES   = 12;
    localparam int PHASE_ITEMS  = 96;
    localparam int HOLD_PHASE   = 5;
    localparam int PAUSE_PHASE  = 6;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;

    typedef longint unsigned t_u64;

    typedef struct {
        logic [SPD_W-1:0] left;
        logic [SPD_W-1:0] right;
        logic             done;
    } t_motor_cmd;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic               func;
        logic signed [31:0] angle;
        logic signed [23:0] turn;
        logic [2:0]         idx;
        logic [23:0]        data;
        bit                 typed;
        t_motor_cmd         cmd;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [23:0] i_cfg_data = '0;

    // model copy of the registers and the turn state
    logic [23:0] kp, kd, ki;
    logic [9:0]  rate, limit;
    logic [15:0] thr;
    longint      tgt, last_err, deriv, integ;
    logic [9:0]  ticks;
    bit          turning;

    t_motor_cmd  motor_cmd_q[$];
    int unsigned err_cnt = 0;
    int unsigned items_sent = 0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;
    bit          hold_served = 1'b0;
    int          hold_left = 0;
    int          stall_left = 0;

    pid_turn_controller #(
        .GAIN_FRAC_BITS(GAIN_FRAC)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("FAIL pid_turn_controller");
        $finish;
    end

    function automatic t_u64 mag(input longint x);
        return (x < 0) ? t_u64'(-x) : t_u64'(x);
    endfunction

    // one gain product, magnitude saturated at the term bound
    function automatic longint gain_prod(input logic [23:0] g, input longint x);
        t_u64 m, p, lim;
        lim = t_u64'(ptc_pkg::TERM_LIMIT);
        m = mag(x);
        if (g == '0 || m == 0)
            return 0;
        p = (m > lim / t_u64'(g)) ? lim : m * t_u64'(g);
        return (x < 0) ? -longint'(p) : longint'(p);
    endfunction

    function automatic bit settled(input longint e, input longint d);
        return (mag(e) + mag(d)) <= t_u64'(thr);
    endfunction

    function automatic t_motor_cmd predict_motor_cmd(input logic func,
            input logic signed [31:0] angle, input logic signed [23:0] turn);
        longint ang, rot, e, acc, sum, speed, nspeed;
        bit stop;
        t_motor_cmd cmd;
        ang = longint'(angle);
        rot = longint'(turn);
        speed = 0;
        cmd.done = 1'b1;
        if (func == FUNC_START) begin
            tgt = ang + rot;
            last_err = 0;
            deriv = 0;
            integ = 0;
            ticks = '0;
            turning = !(settled(rot, 0) || limit == '0);
            cmd.done = !turning;
        end else if (turning) begin
            stop = (ticks >= limit);
            // first sample after a start skips the settle test
            if (ticks != '0 && settled(last_err, deriv))
                stop = 1'b1;
            if (stop) begin
                turning = 1'b0;
            end else begin
                e = tgt - ang;
                deriv = (e - last_err) * longint'(rate);
                acc = integ + e;
                integ = {{16{acc[47]}}, acc[47:0]};
                last_err = e;
                ticks = ticks + 10'd1;
                sum = gain_prod(kp, e) + gain_prod(kd, deriv) + gain_prod(ki, integ);
                speed = sum >>> GAIN_FRAC;
                if (speed > SPEED_MAX)
                    speed = SPEED_MAX;
                if (speed < -SPEED_MAX)
                    speed = -SPEED_MAX;
                cmd.done = 1'b0;
            end
        end
        nspeed = -speed;
        cmd.left = speed[SPD_W-1:0];
        cmd.right = nspeed[SPD_W-1:0];
        return cmd;
    endfunction

    function automatic t_stim_row row_item(input logic func, input logic signed [31:0] angle,
            input logic signed [23:0] turn);
        t_stim_row r;
        r.kind = ROW_ITEM;
        r.func = func;
        r.angle = angle;
        r.turn = turn;
        r.idx = '0;
        r.data = '0;
        r.typed = 1'b0;
        r.cmd.left = '0;
        r.cmd.right = '0;
        r.cmd.done = 1'b0;
        return r;
    endfunction

    function automatic t_stim_row row_chk(input logic func, input logic signed [31:0] angle,
            input logic signed [23:0] turn, input int left, input int right, input logic done);
        t_stim_row r;
        r = row_item(func, angle, turn);
        r.typed = 1'b1;
        r.cmd.left = SPD_W'(left);
        r.cmd.right = SPD_W'(right);
        r.cmd.done = done;
        return r;
    endfunction

    function automatic t_stim_row row_cfg(input logic [2:0] idx, input logic [23:0] data);
        t_stim_row r;
        r = row_item(FUNC_START, '0, '0);
        r.kind = ROW_CFG;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    // stop offering and wait until every predicted command has come back
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (motor_cmd_q.size() != 0);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [23:0] data);
        i_cfg_valid <= 1'b0;
        wait_results_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            ptc_pkg::CFG_PROP_GAIN:  kp = data;
            ptc_pkg::CFG_DERIV_GAIN: kd = data;
            ptc_pkg::CFG_INTEG_GAIN: ki = data;
            ptc_pkg::CFG_TICK_RATE:  rate = data[9:0];
            ptc_pkg::CFG_SETTLE_THR: thr = data[15:0];
            ptc_pkg::CFG_TICK_LIMIT: limit = data[9:0];
            default: ;
        endcase
    endtask

    task automatic send_item(input t_stim_row r);
        t_motor_cmd cmd;
        i_cfg_valid <= 1'b0;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r.turn, r.angle};
        s_tuser  <= r.func;
        do @(posedge i_clk); while (!s_tready);
        cmd = predict_motor_cmd(r.func, r.angle, r.turn);
        motor_cmd_q.push_back(r.typed ? r.cmd : cmd);
        items_sent++;
    endtask

    task automatic set_regs(input logic [23:0] p, input logic [23:0] d, input logic [23:0] i,
            input logic [23:0] rt, input logic [23:0] th, input logic [23:0] lm);
        cfg_write(ptc_pkg::CFG_PROP_GAIN, p);
        cfg_write(ptc_pkg::CFG_DERIV_GAIN, d);
        cfg_write(ptc_pkg::CFG_INTEG_GAIN, i);
        cfg_write(ptc_pkg::CFG_TICK_RATE, rt);
        cfg_write(ptc_pkg::CFG_SETTLE_THR, th);
        cfg_write(ptc_pkg::CFG_TICK_LIMIT, lm);
    endtask

    // mostly converging turns, some with wild samples, some stray requests
    task automatic run_turns(input int unsigned stop_at);
        int pick, cur, k, n;
        logic signed [23:0] rot;
        longint aim, err;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 9);
            if (pick == 9) begin
                send_item(row_item(1'($urandom_range(0, 1)), $urandom, 24'($urandom)));
            end else begin
                cur = $urandom;
                cur = cur >>> $urandom_range(0, 12);
                rot = 24'($urandom);
                rot = rot >>> $urandom_range(0, 12);
                send_item(row_item(FUNC_START, cur, rot));
                aim = longint'(cur) + longint'(rot);
                err = longint'(rot);
                n = $urandom_range(1, 30);
                for (k = 0; k < n && items_sent < stop_at; k++) begin
                    if (pick == 8) begin
                        send_item(row_item(FUNC_SAMPLE, $urandom, 24'($urandom)));
                    end else begin
                        err = err * longint'($urandom_range(0, 6)) / 8;
                        if ($urandom_range(0, 2) == 0)
                            err = err + (int'($urandom_range(0, 8)) - 4);
                        send_item(row_item(FUNC_SAMPLE, 32'(aim - err), 24'($urandom)));
                    end
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_motor_cmd want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (motor_cmd_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("unexpected result: left %0d right %0d done %0d",
                             $signed(m_tdata[13:0]), $signed(m_tdata[27:14]), m_tuser[0]);
            end else begin
                want = motor_cmd_q.pop_front();
                if (m_tdata[13:0] !== want.left || m_tdata[27:14] !== want.right
                        || m_tuser[0] !== want.done) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("mismatch: left %0d/%0d right %0d/%0d done %0d/%0d (exp/act)",
                                 $signed(want.left), $signed(m_tdata[13:0]),
                                 $signed(want.right), $signed(m_tdata[27:14]),
                                 want.done, m_tuser[0]);
                end
            end
        end
    end

    // output side backpressure: random bursts plus one long hold-off
    always @(posedge i_clk) begin
        if (hold_req && !hold_served) begin
            hold_served = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 15);
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin : stimulus
        t_stim_row rows[$];
        int ph;
        int unsigned half;

        kp = ptc_pkg::PROP_GAIN_RST;
        kd = ptc_pkg::DERIV_GAIN_RST;
        ki = ptc_pkg::INTEG_GAIN_RST;
        rate = ptc_pkg::TICK_RATE_RST;
        thr = ptc_pkg::SETTLE_THR_RST;
        limit = ptc_pkg::TICK_LIMIT_RST;
        tgt = 0;
        last_err = 0;
        deriv = 0;
        integ = 0;
        ticks = '0;
        turning = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sample while idle, then starts that settle at once
        rows.push_back(row_chk(FUNC_SAMPLE, 32'sd0, 24'sd0, 0, 0, 1'b1));
        rows.push_back(row_chk(FUNC_START, 32'sd0, 24'sd0, 0, 0, 1'b1));
        rows.push_back(row_chk(FUNC_START, 32'sd1000, 24'sd100, 0, 0, 1'b1));
        // largest positive turn, hit the target, settle
        rows.push_back(row_chk(FUNC_START, 32'sd0, 24'sh7FFFFF, 0, 0, 1'b0));
        rows.push_back(row_chk(FUNC_SAMPLE, 32'sd0, 24'sd0, SPEED_MAX, -SPEED_MAX, 1'b0));
        rows.push_back(row_item(FUNC_SAMPLE, 32'sd8388607, 24'sd0));
        rows.push_back(row_item(FUNC_SAMPLE, 32'sd8388607, 24'sd0));
        rows.push_back(row_chk(FUNC_SAMPLE, 32'sd8388607, 24'sd0, 0, 0, 1'b1));
        // most negative target, angle at the top of its range
        rows.push_back(row_chk(FUNC_START, 32'sh80000000, 24'sh800000, 0, 0, 1'b0));
        rows.push_back(row_chk(FUNC_SAMPLE, 32'sh7FFFFFFF, 24'sd0, -SPEED_MAX, SPEED_MAX, 1'b0));
        // zero tick limit ends the turn at start
        rows.push_back(row_cfg(ptc_pkg::CFG_TICK_LIMIT, 24'd0));
        rows.push_back(row_chk(FUNC_START, 32'sd0, 24'sd5000, 0, 0, 1'b1));
        // tick limit reached, no derivative
        rows.push_back(row_cfg(ptc_pkg::CFG_TICK_LIMIT, 24'd2));
        rows.push_back(row_cfg(ptc_pkg::CFG_TICK_RATE, 24'd0));
        rows.push_back(row_chk(FUNC_START, 32'sd1000, -24'sd5000, 0, 0, 1'b0));
        rows.push_back(row_item(FUNC_SAMPLE, 32'sd1000, 24'sd0));
        rows.push_back(row_item(FUNC_SAMPLE, 32'sd1000, 24'sd0));
        rows.push_back(row_chk(FUNC_SAMPLE, 32'sd1000, 24'sd0, 0, 0, 1'b1));
        // tick limit lowered in the middle of a turn
        rows.push_back(row_cfg(ptc_pkg::CFG_TICK_LIMIT, 24'd80));
        rows.push_back(row_chk(FUNC_START, 32'sd0, 24'sd5000, 0, 0, 1'b0));
        rows.push_back(row_item(FUNC_SAMPLE, 32'sd300, 24'sd0));
        rows.push_back(row_cfg(ptc_pkg::CFG_TICK_LIMIT, 24'd1));
        rows.push_back(row_chk(FUNC_SAMPLE, 32'sd600, 24'sd0, 0, 0, 1'b1));
        // zero threshold, then every gain at its maximum
        rows.push_back(row_cfg(ptc_pkg::CFG_SETTLE_THR, 24'd0));
        rows.push_back(row_chk(FUNC_START, 32'sd0, 24'sd1, 0, 0, 1'b0));
        rows.push_back(row_cfg(ptc_pkg::CFG_PROP_GAIN, 24'hFFFFFF));
        rows.push_back(row_cfg(ptc_pkg::CFG_DERIV_GAIN, 24'hFFFFFF));
        rows.push_back(row_cfg(ptc_pkg::CFG_INTEG_GAIN, 24'hFFFFFF));
        rows.push_back(row_cfg(ptc_pkg::CFG_TICK_RATE, 24'd1000));
        rows.push_back(row_cfg(ptc_pkg::CFG_TICK_LIMIT, 24'd1023));
        rows.push_back(row_cfg(CFG_SPARE_HI, 24'hA5A5A5));
        rows.push_back(row_item(FUNC_SAMPLE, -32'sd5, 24'sd0));
        rows.push_back(row_item(FUNC_SAMPLE, 32'sh80000000, 24'sd0));
        // widest threshold: settle bound inclusive
        rows.push_back(row_cfg(ptc_pkg::CFG_SETTLE_THR, 24'h00FFFF));
        rows.push_back(row_chk(FUNC_START, 32'sd0, 24'sd65535, 0, 0, 1'b1));
        rows.push_back(row_chk(FUNC_START, 32'sd0, 24'sd65536, 0, 0, 1'b0));
        rows.push_back(row_item(FUNC_SAMPLE, 32'sd65000, 24'sd0));

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG)
                cfg_write(rows[i].idx, rows[i].data);
            else
                send_item(rows[i]);
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: set_regs(ptc_pkg::PROP_GAIN_RST, ptc_pkg::DERIV_GAIN_RST,
                            ptc_pkg::INTEG_GAIN_RST, 24'(ptc_pkg::TICK_RATE_RST),
                            24'(ptc_pkg::SETTLE_THR_RST), 24'(ptc_pkg::TICK_LIMIT_RST));
                1: set_regs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd1000, 24'h00FFFF, 24'd1023);
                2: set_regs(24'd0, 24'd0, 24'd0, 24'd1, 24'd0, 24'd1);
                3: set_regs(24'($urandom), 24'($urandom), 24'($urandom),
                            24'($urandom_range(1, 1000)), 24'($urandom_range(0, 65535)),
                            24'($urandom_range(1, 1023)));
                default: set_regs(24'($urandom_range(0, 200000)), 24'($urandom_range(0, 5000)),
                                  24'($urandom_range(0, 2000)), 24'($urandom_range(1, 100)),
                                  24'($urandom_range(0, 2000)), 24'($urandom_range(1, 60)));
            endcase
            if ($urandom_range(0, 1) == 0)
                cfg_write($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 24'($urandom));
            quiet = (ph == NUM_PHASES - 1);
            if (ph == HOLD_PHASE)
                hold_req = 1'b1;
            if (ph == PAUSE_PHASE) begin
                half = items_sent + PHASE_ITEMS / 2;
                run_turns(half);
                wait_results_drained();
                run_turns(half + PHASE_ITEMS / 2);
            end else begin
                run_turns(items_sent + PHASE_ITEMS);
            end
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("PASS pid_turn_controller");
        else
            $display("FAIL pid_turn_controller");
        $finish;
    end

endmodule
